>>> design/bpc_pkg.sv
// shared types, widths and constants of the barometer compensation block
// used by the channel interfaces, the pipeline and the top level; no dependencies
package bpc_pkg;

    localparam int COEF_W = 16;
    localparam int RAW_W = 24;
    localparam int TEMP_W = 20;
    localparam int PRES_W = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0] sens_base;
        logic [COEF_W-1:0] off_base;
        logic [COEF_W-1:0] sens_tc;
        logic [COEF_W-1:0] off_tc;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_slope;
    } coef_t;

    // internal datapath widths
    localparam int DT_W = RAW_W + 1;
    localparam int MC_W = DT_W + COEF_W + 1;
    localparam int MDD_W = 2 * DT_W;
    localparam int T_W = 19;
    localparam int OFF_W = 40;
    localparam int SENS_W = 39;
    localparam int SQ_W = 36;
    localparam int COR_W = 38;
    localparam int SPLIT = 20;
    localparam int PH_W = SENS_W - SPLIT + RAW_W + 1;
    localparam int PL_W = SPLIT + RAW_W;
    localparam int PROD_W = 64;
    localparam int DIFF_W = 48;

    // shift amounts of the compensation formulas
    localparam int REF_SHIFT = 8;
    localparam int T_SHIFT = 23;
    localparam int OFF_BASE_SHIFT = 17;
    localparam int OFF_TC_SHIFT = 6;
    localparam int SENS_BASE_SHIFT = 16;
    localparam int SENS_TC_SHIFT = 7;
    localparam int T2_SHIFT = 31;
    localparam int P_SHIFT1 = 21;
    localparam int P_SHIFT2 = 15;

    // 20.00 degC and -15.00 degC thresholds
    localparam logic signed [T_W-1:0] T_REF = 19'sd2000;
    localparam logic signed [T_W-1:0] T_LOW = -19'sd1500;

endpackage

>>> design/bpc_in_if.sv
// request channel carrying one raw pressure / temperature reading pair
// depends on bpc_pkg for field widths
interface bpc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bpc_pkg::RAW_W-1:0]  raw_pressure;
    logic [bpc_pkg::RAW_W-1:0]  raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

>>> design/bpc_out_if.sv
// result channel carrying compensated temperature and pressure
// depends on bpc_pkg for field widths
interface bpc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp_centi_deg;
    logic signed [bpc_pkg::PRES_W-1:0]  pressure_centi_mbar;

    modport source (output valid, output temp_centi_deg, output pressure_centi_mbar,
                    input ready);
    modport sink (input valid, input temp_centi_deg, input pressure_centi_mbar,
                  output ready);
endinterface

>>> design/bpc_pipe.sv
// nine-stage compensation datapath with per-stage valid bits and stall chain
// depends on bpc_pkg, bpc_in_if and bpc_out_if
module bpc_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  bpc_pkg::coef_t  coef,
    bpc_in_if.sink          raw,
    bpc_out_if.source       comp
);

    localparam int STAGES = 9;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;

    // stage 0: dT
    logic signed [bpc_pkg::DT_W-1:0]    dt_s0_reg, dt_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_s0_reg;
    // stage 1: coefficient products
    logic signed [bpc_pkg::MC_W-1:0]    mt_s1_reg, mt_next;
    logic signed [bpc_pkg::MC_W-1:0]    mo_s1_reg, mo_next;
    logic signed [bpc_pkg::MC_W-1:0]    ms_s1_reg, ms_next;
    logic signed [bpc_pkg::MDD_W-1:0]   mdd_s1_reg, mdd_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_s1_reg;
    // stage 2: first order terms
    logic signed [bpc_pkg::T_W-1:0]     t_s2_reg, t_next;
    logic signed [bpc_pkg::T_W-1:0]     t2_s2_reg, t2_next;
    logic signed [bpc_pkg::OFF_W-1:0]   off_s2_reg, off_next;
    logic signed [bpc_pkg::SENS_W-1:0]  sens_s2_reg, sens_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_s2_reg;
    // stage 3: squares
    logic signed [bpc_pkg::T_W-1:0]     lo, vl;
    logic signed [2*bpc_pkg::T_W-1:0]   lo_sq, vl_sq;
    logic [bpc_pkg::SQ_W-1:0]           sq_s3_reg, sq2_s3_reg;
    logic                               cold_s3_reg, frigid_s3_reg;
    logic signed [bpc_pkg::T_W-1:0]     t_s3_reg, t2_s3_reg;
    logic signed [bpc_pkg::OFF_W-1:0]   off_s3_reg;
    logic signed [bpc_pkg::SENS_W-1:0]  sens_s3_reg;
    logic [bpc_pkg::RAW_W-1:0]          d1_s3_reg;
    // stage 4: second order corrections
    logic [bpc_pkg::COR_W-1:0]          sq_w, sq2_w, five_sq;
    logic [bpc_pkg::COR_W-1:0]          off2_s4_reg, off2_next;
    logic [bpc_pkg::COR_W-1:0]          sens2_s4_reg, sens2_next;
    logic                               cold_s4_reg;
    logic signed [bpc_pkg::T_W-1:0]     t_s4_reg, t2_s4_reg;
    logic signed [bpc_pkg::OFF_W-1:0]   off_s4_reg;
    logic signed [bpc_pkg::SENS_W-1:0]  sens_s4_reg;
    logic [bpc_pkg::RAW_W-1:0]          d1_s4_reg;
    // stage 5: corrected values
    logic signed [bpc_pkg::TEMP_W-1:0]  tc_s5_reg, tc_next;
    logic signed [bpc_pkg::OFF_W-1:0]   offc_s5_reg, offc_next;
    logic signed [bpc_pkg::SENS_W-1:0]  sensc_s5_reg, sensc_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_s5_reg;
    // stage 6: split sens * d1 partial products
    logic signed [bpc_pkg::PH_W-1:0]    ph_s6_reg, ph_next;
    logic [bpc_pkg::PL_W-1:0]           pl_s6_reg, pl_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  tc_s6_reg;
    logic signed [bpc_pkg::OFF_W-1:0]   offc_s6_reg;
    // stage 7: full product
    logic signed [bpc_pkg::PROD_W-1:0]  prod_s7_reg, prod_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  tc_s7_reg;
    logic signed [bpc_pkg::OFF_W-1:0]   offc_s7_reg;
    // stage 8: output register
    logic signed [bpc_pkg::DIFF_W-1:0]  diff;
    logic signed [bpc_pkg::PRES_W-1:0]  pres_s8_reg, pres_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  tc_s8_reg;

    // a stage takes new data when it is empty or the one after it moves
    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || comp.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign raw.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= raw.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        dt_next = $signed({1'b0, raw.raw_temperature})
                - $signed(bpc_pkg::DT_W'(coef.ref_temp) << bpc_pkg::REF_SHIFT);

        mt_next = dt_s0_reg * $signed({1'b0, coef.temp_slope});
        mo_next = dt_s0_reg * $signed({1'b0, coef.off_tc});
        ms_next = dt_s0_reg * $signed({1'b0, coef.sens_tc});
        mdd_next = dt_s0_reg * dt_s0_reg;

        t_next = bpc_pkg::T_REF + bpc_pkg::T_W'(mt_s1_reg >>> bpc_pkg::T_SHIFT);
        t2_next = bpc_pkg::T_W'(mdd_s1_reg >>> bpc_pkg::T2_SHIFT);
        off_next = $signed(bpc_pkg::OFF_W'(coef.off_base) << bpc_pkg::OFF_BASE_SHIFT)
                 + bpc_pkg::OFF_W'(mo_s1_reg >>> bpc_pkg::OFF_TC_SHIFT);
        sens_next = $signed(bpc_pkg::SENS_W'(coef.sens_base) << bpc_pkg::SENS_BASE_SHIFT)
                  + bpc_pkg::SENS_W'(ms_s1_reg >>> bpc_pkg::SENS_TC_SHIFT);

        lo = t_s2_reg - bpc_pkg::T_REF;
        vl = t_s2_reg - bpc_pkg::T_LOW;
        lo_sq = lo * lo;
        vl_sq = vl * vl;

        // 5*sq, 7*sq2 and 11*sq2 as shift-add, all terms non-negative
        sq_w = bpc_pkg::COR_W'(sq_s3_reg);
        sq2_w = bpc_pkg::COR_W'(sq2_s3_reg);
        five_sq = (sq_w << 2) + sq_w;
        off2_next = (five_sq >> 1) + (frigid_s3_reg ? (sq2_w << 3) - sq2_w : '0);
        sens2_next = (five_sq >> 2)
                   + (frigid_s3_reg ? ((sq2_w << 3) + (sq2_w << 1) + sq2_w) >> 1 : '0);

        tc_next = cold_s4_reg
                ? bpc_pkg::TEMP_W'(t_s4_reg) - bpc_pkg::TEMP_W'(t2_s4_reg)
                : bpc_pkg::TEMP_W'(t_s4_reg);
        offc_next = cold_s4_reg
                  ? off_s4_reg - $signed(bpc_pkg::OFF_W'(off2_s4_reg))
                  : off_s4_reg;
        sensc_next = cold_s4_reg
                   ? sens_s4_reg - $signed(bpc_pkg::SENS_W'(sens2_s4_reg))
                   : sens_s4_reg;

        // sens = hi * 2^SPLIT + lo, hi signed, lo unsigned
        ph_next = $signed(sensc_s5_reg[bpc_pkg::SENS_W-1:bpc_pkg::SPLIT])
                * $signed({1'b0, d1_s5_reg});
        pl_next = sensc_s5_reg[bpc_pkg::SPLIT-1:0] * d1_s5_reg;

        prod_next = (bpc_pkg::PROD_W'(ph_s6_reg) <<< bpc_pkg::SPLIT)
                  + $signed(bpc_pkg::PROD_W'(pl_s6_reg));

        diff = bpc_pkg::DIFF_W'(prod_s7_reg >>> bpc_pkg::P_SHIFT1)
             - bpc_pkg::DIFF_W'(offc_s7_reg);
        pres_next = bpc_pkg::PRES_W'(diff >>> bpc_pkg::P_SHIFT2);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_s0_reg <= dt_next;
            d1_s0_reg <= raw.raw_pressure;
        end
        if (en[1])
        begin
            mt_s1_reg <= mt_next;
            mo_s1_reg <= mo_next;
            ms_s1_reg <= ms_next;
            mdd_s1_reg <= mdd_next;
            d1_s1_reg <= d1_s0_reg;
        end
        if (en[2])
        begin
            t_s2_reg <= t_next;
            t2_s2_reg <= t2_next;
            off_s2_reg <= off_next;
            sens_s2_reg <= sens_next;
            d1_s2_reg <= d1_s1_reg;
        end
        if (en[3])
        begin
            sq_s3_reg <= bpc_pkg::SQ_W'(lo_sq);
            sq2_s3_reg <= bpc_pkg::SQ_W'(vl_sq);
            cold_s3_reg <= t_s2_reg < bpc_pkg::T_REF;
            frigid_s3_reg <= t_s2_reg < bpc_pkg::T_LOW;
            t_s3_reg <= t_s2_reg;
            t2_s3_reg <= t2_s2_reg;
            off_s3_reg <= off_s2_reg;
            sens_s3_reg <= sens_s2_reg;
            d1_s3_reg <= d1_s2_reg;
        end
        if (en[4])
        begin
            off2_s4_reg <= off2_next;
            sens2_s4_reg <= sens2_next;
            cold_s4_reg <= cold_s3_reg;
            t_s4_reg <= t_s3_reg;
            t2_s4_reg <= t2_s3_reg;
            off_s4_reg <= off_s3_reg;
            sens_s4_reg <= sens_s3_reg;
            d1_s4_reg <= d1_s3_reg;
        end
        if (en[5])
        begin
            tc_s5_reg <= tc_next;
            offc_s5_reg <= offc_next;
            sensc_s5_reg <= sensc_next;
            d1_s5_reg <= d1_s4_reg;
        end
        if (en[6])
        begin
            ph_s6_reg <= ph_next;
            pl_s6_reg <= pl_next;
            tc_s6_reg <= tc_s5_reg;
            offc_s6_reg <= offc_s5_reg;
        end
        if (en[7])
        begin
            prod_s7_reg <= prod_next;
            tc_s7_reg <= tc_s6_reg;
            offc_s7_reg <= offc_s6_reg;
        end
        if (en[8])
        begin
            pres_s8_reg <= pres_next;
            tc_s8_reg <= tc_s7_reg;
        end
    end

    assign comp.valid = v_reg[STAGES-1];
    assign comp.temp_centi_deg = tc_s8_reg;
    assign comp.pressure_centi_mbar = pres_s8_reg;

endmodule

>>> design/baro_pressure_compensation.sv
// a request passes the 9 bpc_pipe stages in order; stage 8 is the output register
// throughput: one request per cycle unless the output stalls; widest step: the 39 x 24
// bit sens * d1 product, split over two stages as two partial products and a final add
// a stalled result holds only the stages behind it; empty stages keep filling
// reset clears the six calibration words to zero and empties the pipeline
// depends on bpc_pkg, bpc_in_if, bpc_out_if and bpc_pipe
module baro_pressure_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]          cfg_data,
    bpc_in_if.sink                              raw,
    bpc_out_if.source                           comp
);

    bpc_pkg::coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bpc_pkg::CFG_SENS_BASE:  coef_reg.sens_base <= cfg_data;
                bpc_pkg::CFG_OFF_BASE:   coef_reg.off_base <= cfg_data;
                bpc_pkg::CFG_SENS_TC:    coef_reg.sens_tc <= cfg_data;
                bpc_pkg::CFG_OFF_TC:     coef_reg.off_tc <= cfg_data;
                bpc_pkg::CFG_REF_TEMP:   coef_reg.ref_temp <= cfg_data;
                bpc_pkg::CFG_TEMP_SLOPE: coef_reg.temp_slope <= cfg_data;
                default:                 ;
            endcase
        end
    end

    bpc_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef_reg),
        .raw   (raw),
        .comp  (comp)
    );

    // no bubbles held back: an empty or draining output lets a request in
    a_fill_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!comp.valid || comp.ready) |-> raw.ready)
        else $error("input stalled while output stage free");

    // corrected temperature stays in its physical range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        comp.valid |-> (comp.temp_centi_deg >= -20'sd261000
                        && comp.temp_centi_deg <= 20'sd133100))
        else $error("temperature out of range");

    // pressure result never needs more than 27 signed bits
    a_pres_sign: assert property (@(posedge clk) disable iff (!rst_n)
        comp.valid |-> (comp.pressure_centi_mbar[31:26] == 6'b000000
                        || comp.pressure_centi_mbar[31:26] == 6'b111111))
        else $error("pressure sign extension broken");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == bpc_pkg::CFG_TEMP_SLOPE)
        |=> coef_reg.temp_slope == $past(cfg_data))
        else $error("calibration write lost");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// self-checking bench for baro_pressure_compensation: random reading pairs over several
// calibration sets, checked against an in-bench integer compensation predictor
// depends on bpc_pkg, bpc_in_if, bpc_out_if and the design top level
module tb;

    localparam int CLK_PERIOD = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [bpc_pkg::RAW_W-1:0] RAW_MAX = '1;

    typedef enum logic [1:0] {BAND_MILD, BAND_COLD, BAND_FRIGID} band_t;

    typedef struct packed {
        logic [bpc_pkg::RAW_W-1:0] pres;
        logic [bpc_pkg::RAW_W-1:0] temp;
    } reading_t;

    typedef struct packed {
        logic signed [bpc_pkg::TEMP_W-1:0] temp;
        logic signed [bpc_pkg::PRES_W-1:0] pres;
        band_t band;
    } compensated_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write;
    logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpc_pkg::COEF_W-1:0] cfg_data;

    bpc_in_if raw_ch ();
    bpc_out_if comp_ch ();

    baro_pressure_compensation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw       (raw_ch),
        .comp      (comp_ch)
    );

    bpc_pkg::coef_t active_coefs = '0;
    reading_t readings_to_send[$];
    compensated_t compensated_due[$];
    reading_t next_reading;
    compensated_t predicted;
    compensated_t oldest_due;

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_cold = 0;
    int n_frigid = 0;
    int n_sets = 1;
    int n_cycles = 0;
    int src_gap = 0;
    int src_calm = 0;
    int sink_stall = 0;
    int sink_calm = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // integer compensation, shifts are arithmetic (floor)
    function automatic compensated_t compensate(bpc_pkg::coef_t c,
                                                logic [bpc_pkg::RAW_W-1:0] d1,
                                                logic [bpc_pkg::RAW_W-1:0] d2);
        longint dt, t, off, sens, t2, lo, sq, off2, sens2, vl, sq2, p;
        compensated_t r;
        dt = longint'(d2) - longint'(c.ref_temp) * 256;
        t = 2000 + ((dt * longint'(c.temp_slope)) >>> 23);
        off = longint'(c.off_base) * 131072 + ((dt * longint'(c.off_tc)) >>> 6);
        sens = longint'(c.sens_base) * 65536 + ((dt * longint'(c.sens_tc)) >>> 7);
        r.band = BAND_MILD;
        if (t < 2000)
        begin
            r.band = BAND_COLD;
            t2 = (dt * dt) >>> 31;
            lo = t - 2000;
            sq = lo * lo;
            off2 = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (t < -1500)
            begin
                r.band = BAND_FRIGID;
                vl = t + 1500;
                sq2 = vl * vl;
                off2 = off2 + 7 * sq2;
                sens2 = sens2 + ((11 * sq2) >>> 1);
            end
            t = t - t2;
            off = off - off2;
            sens = sens - sens2;
        end
        p = (((sens * longint'(d1)) >>> 21) - off) >>> 15;
        r.temp = t[bpc_pkg::TEMP_W-1:0];
        r.pres = p[bpc_pkg::PRES_W-1:0];
        return r;
    endfunction

    // mostly back-to-back, some short gaps, rare long ones, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [bpc_pkg::RAW_W-1:0] clamp_raw(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(RAW_MAX))
            return RAW_MAX;
        return v[bpc_pkg::RAW_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic push_reading(logic [bpc_pkg::RAW_W-1:0] d1,
                                logic [bpc_pkg::RAW_W-1:0] d2);
        reading_t rd;
        rd.pres = d1;
        rd.temp = d2;
        readings_to_send.push_back(rd);
        n_queued++;
    endtask

    // temperature readings lean toward the reference point and the cold side
    task automatic push_random(int count);
        longint ref_code, v;
        logic [bpc_pkg::RAW_W-1:0] d1;
        int mode;
        ref_code = longint'(active_coefs.ref_temp) * 256;
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 9);
            d1 = bpc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
            if (mode == 9)
                d1 = ($urandom_range(0, 1) == 1) ? RAW_MAX : '0;
            case (mode % 3)
                0: v = longint'($urandom_range(0, RAW_MAX));
                1: v = ref_code - longint'($urandom_range(0, 4194304));
                default: v = ref_code + longint'($urandom_range(0, 1048576)) - 524288;
            endcase
            push_reading(d1, clamp_raw(v));
        end
    endtask

    // field extremes plus readings at the 20.00 and -15.00 degC switch points
    task automatic push_directed();
        longint ref_code, dt_edge;
        longint probes [7];
        logic [bpc_pkg::RAW_W-1:0] d1;
        ref_code = longint'(active_coefs.ref_temp) * 256;
        if (active_coefs.temp_slope == '0)
            dt_edge = -1000000;
        else
            dt_edge = -((longint'(3500) << 23) / longint'(active_coefs.temp_slope));
        probes = '{0, longint'(RAW_MAX), ref_code, ref_code - 1, ref_code + dt_edge,
                   ref_code + dt_edge - 1, ref_code - 4194304};
        foreach (probes[i])
        begin
            case (i % 3)
                0: d1 = '0;
                1: d1 = RAW_MAX;
                default: d1 = bpc_pkg::RAW_W'($urandom_range(0, RAW_MAX));
            endcase
            push_reading(d1, clamp_raw(probes[i]));
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || compensated_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_coefs(bpc_pkg::coef_t c);
        logic [bpc_pkg::CFG_IDX_W-1:0] idx [8];
        logic [bpc_pkg::COEF_W-1:0] word [8];
        idx = '{bpc_pkg::CFG_SENS_BASE, bpc_pkg::CFG_OFF_BASE, bpc_pkg::CFG_SENS_TC,
                bpc_pkg::CFG_OFF_TC, bpc_pkg::CFG_REF_TEMP, bpc_pkg::CFG_TEMP_SLOPE,
                CFG_SPARE_LO, CFG_SPARE_HI};
        word = '{c.sens_base, c.off_base, c.sens_tc, c.off_tc, c.ref_temp, c.temp_slope,
                 ~c.sens_base, ~c.temp_slope};
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= word[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
        // writes to spare indexes must not land anywhere
        active_coefs = c;
        n_sets++;
    endtask

    task automatic run_phase(bit load, bpc_pkg::coef_t c, bit directed, int count,
                             bit pause_mid);
        if (load)
            load_coefs(c);
        if (directed)
            push_directed();
        push_random(count / 2);
        if (pause_mid)
            wait_drained();
        push_random(count - count / 2);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_ch.valid <= 1'b0;
            raw_ch.raw_pressure <= '0;
            raw_ch.raw_temperature <= '0;
            src_gap = 0;
        end
        else
        begin
            if (raw_ch.valid && raw_ch.ready)
            begin
                predicted = compensate(active_coefs, raw_ch.raw_pressure,
                                       raw_ch.raw_temperature);
                compensated_due.push_back(predicted);
                n_accepted++;
                if (predicted.band != BAND_MILD)
                    n_cold++;
                if (predicted.band == BAND_FRIGID)
                    n_frigid++;
            end
            if (!raw_ch.valid || raw_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    raw_ch.valid <= 1'b0;
                end
                else if (readings_to_send.size() > 0)
                begin
                    next_reading = readings_to_send.pop_front();
                    raw_ch.valid <= 1'b1;
                    raw_ch.raw_pressure <= next_reading.pres;
                    raw_ch.raw_temperature <= next_reading.temp;
                    src_gap = pick_gap(src_calm);
                end
                else
                    raw_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_ch.ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (comp_ch.valid && comp_ch.ready)
            begin
                n_checked++;
                if (compensated_due.size() == 0)
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              n_checked));
                else
                begin
                    oldest_due = compensated_due.pop_front();
                    if (comp_ch.temp_centi_deg !== oldest_due.temp)
                        report_mismatch($sformatf("result %0d temp_centi_deg %0d, want %0d",
                            n_checked, comp_ch.temp_centi_deg, oldest_due.temp));
                    if (comp_ch.pressure_centi_mbar !== oldest_due.pres)
                        report_mismatch($sformatf(
                            "result %0d pressure_centi_mbar %0d, want %0d", n_checked,
                            comp_ch.pressure_centi_mbar, oldest_due.pres));
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                comp_ch.ready <= 1'b0;
            end
            else
            begin
                comp_ch.ready <= 1'b1;
                sink_stall = pick_gap(sink_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                     compensated_due.size());
            $display("baro_pressure_compensation regression: fail");
            $finish;
        end
    end

    initial
    begin
        bpc_pkg::coef_t typical, rnd;
        typical = '{sens_base: 16'd46372, off_base: 16'd43981, sens_tc: 16'd29059,
                    off_tc: 16'd27842, ref_temp: 16'd31553, temp_slope: 16'd28165};
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // calibration words still at their reset value
        run_phase(1'b0, '0, 1'b0, 60, 1'b0);
        run_phase(1'b1, typical, 1'b1, 300, 1'b1);
        run_phase(1'b1, '1, 1'b1, 200, 1'b0);
        // deep cold: reference at the top, steepest slope
        rnd = {$urandom, $urandom, $urandom};
        rnd.ref_temp = '1;
        rnd.temp_slope = '1;
        run_phase(1'b1, rnd, 1'b0, 200, 1'b0);
        // hot side: reference at zero
        rnd = {$urandom, $urandom, $urandom};
        rnd.ref_temp = '0;
        rnd.temp_slope = '1;
        run_phase(1'b1, rnd, 1'b0, 150, 1'b0);
        run_phase(1'b1, '0, 1'b0, 40, 1'b0);
        rnd = {$urandom, $urandom, $urandom};
        run_phase(1'b1, rnd, 1'b0, 300, 1'b1);

        $display("%0d reading pairs over %0d calibration sets, %0d results checked",
                 n_accepted, n_sets, n_checked);
        $display("%0d took the below-20 degC correction, %0d the below -15 degC term",
                 n_cold, n_frigid);
        if (n_errors == 0)
            $display("baro_pressure_compensation regression: pass");
        else
            $display("baro_pressure_compensation regression: fail");
        $finish;
    end

endmodule
